>>> rtl/core/cst_pkg.sv
// Shared codes, field widths and cell control type for the chunked stack.
package cst_pkg;

	localparam int COMMAND_W       = 2;
	localparam int PUSH_VALUE_W    = 32;
	localparam int STACK_INDEX_W   = 3;
	localparam int STATUS_W        = 2;
	localparam int TOP_VALUE_W     = 32;
	localparam int STACK_COUNT_W   = 4;
	localparam int ELEMENT_COUNT_W = 6;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam logic [COMMAND_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [COMMAND_W-1:0] CMD_POP    = 2'd1;
	localparam logic [COMMAND_W-1:0] CMD_POP_AT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_REMOVE
	} cell_kind_t;

endpackage

>>> rtl/core/cst_cell.sv
// One stack cell: holds one entry and trades it with its neighbors.
module cst_cell #(
	parameter int WIDTH   = 32,
	parameter int DEPTH_W = 6,
	parameter int INDEX   = 0
) (
	input  logic                clk,
	input  cst_pkg::cell_kind_t kind,
	input  logic [DEPTH_W-1:0]  depth,
	input  logic [WIDTH-1:0]    upper,
	input  logic [WIDTH-1:0]    lower,
	output logic [WIDTH-1:0]    value
);

	logic [WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		case (kind)
			cst_pkg::CELL_PUSH: begin
				value_q <= upper;
			end
			cst_pkg::CELL_REMOVE: begin
				if (DEPTH_W'(INDEX) >= depth) begin
					value_q <= lower;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;

endmodule

>>> rtl/core/cst_ctrl.sv
// Command decode, element and sub-stack counters and status for the chunked stack.
module cst_ctrl #(
	parameter int PLATES   = 4,
	parameter int STACKS   = 8,
	parameter int CAPACITY = PLATES * STACKS,
	parameter int COUNT_W  = $clog2(CAPACITY + 1),
	parameter int QUOT_W   = $clog2(STACKS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [cst_pkg::COMMAND_W-1:0]        command,
	input  logic [cst_pkg::STACK_INDEX_W-1:0]    stack_index,
	output cst_pkg::cell_kind_t                  kind,
	output logic [COUNT_W-1:0]                   depth,
	output logic [cst_pkg::STATUS_W-1:0]         status,
	output logic [COUNT_W-1:0]                   count,
	output logic [QUOT_W-1:0]                    stacks
);

	localparam int REM_W = (PLATES > 1) ? $clog2(PLATES) : 1;

	logic [COUNT_W-1:0]            count_q;
	logic [QUOT_W-1:0]             quot_q;
	logic [REM_W-1:0]              rem_q;
	logic [cst_pkg::STATUS_W-1:0]  status_q;
	logic [cst_pkg::STATUS_W-1:0]  status_d;
	logic [COUNT_W-1:0]            pos;
	logic                          is_last;
	logic                          inc;
	logic                          dec;

	assign stacks  = (quot_q == '0 && rem_q == '0) ? QUOT_W'(1)
	               : quot_q + QUOT_W'(rem_q != '0);
	assign is_last = (int'(stack_index) + 1) == int'(stacks);
	assign pos     = COUNT_W'(int'(stack_index) * PLATES + PLATES - 1);

	always_comb begin
		kind     = cst_pkg::CELL_HOLD;
		depth    = '0;
		status_d = cst_pkg::ST_OK;
		inc      = 1'b0;
		dec      = 1'b0;
		if (accept) begin
			unique case (command)
				cst_pkg::CMD_PUSH: begin
					if (count_q == COUNT_W'(CAPACITY)) begin
						status_d = cst_pkg::ST_FULL;
					end else begin
						kind = cst_pkg::CELL_PUSH;
						inc  = 1'b1;
					end
				end
				cst_pkg::CMD_POP: begin
					if (count_q == '0) begin
						status_d = cst_pkg::ST_EMPTY;
					end else begin
						kind = cst_pkg::CELL_REMOVE;
						dec  = 1'b1;
					end
				end
				cst_pkg::CMD_POP_AT: begin
					if (is_last) begin
						if (count_q == '0) begin
							status_d = cst_pkg::ST_EMPTY;
						end else begin
							kind = cst_pkg::CELL_REMOVE;
							dec  = 1'b1;
						end
					end else if (int'(stack_index) >= int'(stacks)) begin
						status_d = cst_pkg::ST_BAD_INDEX;
					end else begin
						kind  = cst_pkg::CELL_REMOVE;
						depth = count_q - COUNT_W'(1) - pos;
						dec   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			quot_q   <= '0;
			rem_q    <= '0;
			status_q <= cst_pkg::ST_OK;
		end else begin
			if (accept) begin
				status_q <= status_d;
			end
			if (inc) begin
				count_q <= count_q + COUNT_W'(1);
				if (rem_q == REM_W'(PLATES - 1)) begin
					rem_q  <= '0;
					quot_q <= quot_q + QUOT_W'(1);
				end else begin
					rem_q <= rem_q + REM_W'(1);
				end
			end else if (dec) begin
				count_q <= count_q - COUNT_W'(1);
				if (rem_q == '0) begin
					rem_q  <= REM_W'(PLATES - 1);
					quot_q <= quot_q - QUOT_W'(1);
				end else begin
					rem_q <= rem_q - REM_W'(1);
				end
			end
		end
	end

	assign status = status_q;
	assign count  = count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= CAPACITY)
		else $error("element count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) == int'(quot_q) * PLATES + int'(rem_q))
		else $error("sub-stack counters out of step with element count");

	assert property (@(posedge clk) disable iff (!arst_n)
		kind == cst_pkg::CELL_REMOVE |-> count_q != '0 && depth < count_q)
		else $error("remove request on an empty stack or past the bottom");

	assert property (@(posedge clk) disable iff (!arst_n)
		inc |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("push did not advance the element count");

endmodule

>>> rtl/core/chunked_stack_with_pop_at.sv
// Top level of the chunked stack with pop-at, built as a chain of storage cells.
// Latency: a request's result is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle while m_tready is high; every command, pop-at included, shifts the cell chain.
// The result register is refreshed at the same edge it is taken, so no bubble under back-pressure.
// Reset (arst_n low, asynchronous) empties the stack and drops any pending result.
// Cell contents are not reset; only entries below the element count are ever shown.
module chunked_stack_with_pop_at #(
	parameter int PLATES_PER_STACK = 4,
	parameter int MAX_STACKS       = 8,
	parameter int VALUE_WIDTH      = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// command[1:0], push_value[33:2], stack_index[36:34], zero fill above
	input  logic [cst_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], top_value[33:2], is_empty[34], stack_count[38:35],
	// element_count[44:39], zero fill above
	output logic [cst_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CAPACITY = PLATES_PER_STACK * MAX_STACKS;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int QUOT_W   = $clog2(MAX_STACKS + 1);

	logic                                 accept;
	logic                                 out_valid_q;
	logic [cst_pkg::COMMAND_W-1:0]        command;
	logic [cst_pkg::PUSH_VALUE_W-1:0]     push_value;
	logic [cst_pkg::STACK_INDEX_W-1:0]    stack_index;
	cst_pkg::cell_kind_t                  kind;
	logic [COUNT_W-1:0]                   depth;
	logic [cst_pkg::STATUS_W-1:0]         status;
	logic [COUNT_W-1:0]                   count;
	logic [QUOT_W-1:0]                    stacks;
	logic [VALUE_WIDTH-1:0]               push_cell;
	logic [VALUE_WIDTH-1:0]               cell_value [CAPACITY];
	logic [cst_pkg::TOP_VALUE_W-1:0]      top_value;
	logic                                 is_empty;

	assign command     = s_tdata[1:0];
	assign push_value  = s_tdata[33:2];
	assign stack_index = s_tdata[36:34];
	assign push_cell   = VALUE_WIDTH'(push_value);

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	cst_ctrl #(
		.PLATES (PLATES_PER_STACK),
		.STACKS (MAX_STACKS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.command     (command),
		.stack_index (stack_index),
		.kind        (kind),
		.depth       (depth),
		.status      (status),
		.count       (count),
		.stacks      (stacks)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] upper;
		logic [VALUE_WIDTH-1:0] lower;

		if (i == 0) begin : g_head
			assign upper = push_cell;
		end else begin : g_mid
			assign upper = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign lower = cell_value[i];
		end else begin : g_body
			assign lower = cell_value[i+1];
		end

		cst_cell #(
			.WIDTH   (VALUE_WIDTH),
			.DEPTH_W (COUNT_W),
			.INDEX   (i)
		) u_cell (
			.clk   (clk),
			.kind  (kind),
			.depth (depth),
			.upper (upper),
			.lower (lower),
			.value (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign is_empty  = (count == '0);
	assign top_value = is_empty ? '0 : cst_pkg::TOP_VALUE_W'(cell_value[0]);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		3'b000,
		cst_pkg::ELEMENT_COUNT_W'(count),
		cst_pkg::STACK_COUNT_W'(stacks),
		is_empty,
		top_value,
		status
	};

endmodule
